// ===== hw/rtl/smle_pkg.sv =====
// Shared types and codes for the sorted multimap list engine.
package smle_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int MCNT_W      = 6;

    typedef enum logic [1:0] {
        FN_INSERT     = 2'd0,
        FN_SEARCH     = 2'd1,
        FN_REMOVE     = 2'd2,
        FN_REMOVE_KEY = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CODE_OK   = 2'd0,
        CODE_NF   = 2'd1,
        CODE_FULL = 2'd2
    } t_code;

    // read address source; every source but RD_NONE/RD_FREE also moves the cursor
    typedef enum logic [2:0] {
        RD_NONE,
        RD_HEAD,
        RD_NEXT,
        RD_SAVED,
        RD_FIRST,
        RD_FREE
    } t_rd;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_POP,
        WR_LINK_N,
        WR_LINK_NB,
        WR_UL_NB,
        WR_UL_FREE,
        WR_UL_FH
    } t_wr;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_POP,
        ST_WALK_INS,
        ST_INS_LINK,
        ST_INS_NB,
        ST_WALK_RP,
        ST_WALK_FIND,
        ST_COUNT,
        ST_WALK2,
        ST_EMIT2,
        ST_UL1,
        ST_UL2,
        ST_UL3,
        ST_P2_NEXT,
        ST_E_OK,
        ST_E_NF,
        ST_E_FULL
    } t_state;

    typedef struct packed {
        logic  in_rdy;
        t_rd   rd;
        t_wr   wr;
        logic  cap;
        logic  first_ld;
        logic  mcnt_clr;
        logic  mcnt_inc;
        logic  mcnt_dec;
        logic  rep_ld;
        logic  emit;
        t_code code;
        logic  val_sel;
        logic  cnt_rep;
        logic  last;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  cur_node;
        logic  key_eq;
        logic  val_eq;
        logic  goes_first;
        logic  free_node;
        logic  mcnt_full;
        logic  mcnt_one;
        logic  out_free;
    } t_sts;

endpackage

// ===== hw/rtl/smle_ctrl.sv =====
// Sequencer for the list engine: walks, linking and result issue.
module smle_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  smle_pkg::t_sts  i_sts,
    output smle_pkg::t_cmd  o_cmd
);

    smle_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smle_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            smle_pkg::ST_IDLE: begin
                o_cmd.in_rdy = 1'b1;
                if (i_in_valid) begin
                    n_state = smle_pkg::ST_DISPATCH;
                end
            end
            smle_pkg::ST_DISPATCH: begin
                o_cmd.mcnt_clr = 1'b1;
                case (i_sts.func)
                    smle_pkg::FN_INSERT: begin
                        if (i_sts.free_node) begin
                            o_cmd.rd = smle_pkg::RD_FREE;
                            n_state  = smle_pkg::ST_INS_POP;
                        end else begin
                            n_state = smle_pkg::ST_E_FULL;
                        end
                    end
                    smle_pkg::FN_REMOVE: begin
                        o_cmd.rd = smle_pkg::RD_HEAD;
                        n_state  = smle_pkg::ST_WALK_RP;
                    end
                    default: begin
                        o_cmd.rd = smle_pkg::RD_HEAD;
                        n_state  = smle_pkg::ST_WALK_FIND;
                    end
                endcase
            end
            smle_pkg::ST_INS_POP: begin
                o_cmd.wr = smle_pkg::WR_POP;
                o_cmd.rd = smle_pkg::RD_HEAD;
                n_state  = smle_pkg::ST_WALK_INS;
            end
            smle_pkg::ST_WALK_INS: begin
                if (!i_sts.cur_node) begin
                    n_state = smle_pkg::ST_INS_LINK;
                end else if (i_sts.goes_first) begin
                    o_cmd.cap = 1'b1;
                    n_state   = smle_pkg::ST_INS_LINK;
                end else begin
                    o_cmd.rd = smle_pkg::RD_NEXT;
                end
            end
            smle_pkg::ST_INS_LINK: begin
                o_cmd.wr = smle_pkg::WR_LINK_N;
                n_state  = smle_pkg::ST_INS_NB;
            end
            smle_pkg::ST_INS_NB: begin
                o_cmd.wr = smle_pkg::WR_LINK_NB;
                n_state  = smle_pkg::ST_E_OK;
            end
            smle_pkg::ST_WALK_RP: begin
                if (!i_sts.cur_node) begin
                    n_state = smle_pkg::ST_E_NF;
                end else if (i_sts.key_eq && i_sts.val_eq) begin
                    o_cmd.cap = 1'b1;
                    n_state   = smle_pkg::ST_UL1;
                end else begin
                    o_cmd.rd = smle_pkg::RD_NEXT;
                end
            end
            smle_pkg::ST_WALK_FIND: begin
                if (!i_sts.cur_node) begin
                    n_state = smle_pkg::ST_E_NF;
                end else begin
                    o_cmd.rd = smle_pkg::RD_NEXT;
                    if (i_sts.key_eq) begin
                        o_cmd.first_ld = 1'b1;
                        o_cmd.mcnt_inc = 1'b1;
                        n_state        = smle_pkg::ST_COUNT;
                    end
                end
            end
            smle_pkg::ST_COUNT: begin
                // run of equal keys ends at a mismatch, the tail, or the result cap
                if (!i_sts.cur_node || !i_sts.key_eq || i_sts.mcnt_full) begin
                    o_cmd.rep_ld = 1'b1;
                    o_cmd.rd     = smle_pkg::RD_FIRST;
                    n_state      = smle_pkg::ST_WALK2;
                end else begin
                    o_cmd.mcnt_inc = 1'b1;
                    o_cmd.rd       = smle_pkg::RD_NEXT;
                end
            end
            smle_pkg::ST_WALK2: begin
                o_cmd.cap = 1'b1;
                n_state   = smle_pkg::ST_EMIT2;
            end
            smle_pkg::ST_EMIT2: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.code    = smle_pkg::CODE_OK;
                    o_cmd.val_sel = 1'b1;
                    o_cmd.cnt_rep = 1'b1;
                    o_cmd.last    = i_sts.mcnt_one;
                    n_state = (i_sts.func == smle_pkg::FN_REMOVE_KEY) ?
                              smle_pkg::ST_UL1 : smle_pkg::ST_P2_NEXT;
                end
            end
            smle_pkg::ST_UL1: begin
                o_cmd.wr = smle_pkg::WR_UL_NB;
                n_state  = smle_pkg::ST_UL2;
            end
            smle_pkg::ST_UL2: begin
                o_cmd.wr = smle_pkg::WR_UL_FREE;
                n_state  = smle_pkg::ST_UL3;
            end
            smle_pkg::ST_UL3: begin
                o_cmd.wr = smle_pkg::WR_UL_FH;
                n_state = (i_sts.func == smle_pkg::FN_REMOVE) ?
                          smle_pkg::ST_E_OK : smle_pkg::ST_P2_NEXT;
            end
            smle_pkg::ST_P2_NEXT: begin
                o_cmd.mcnt_dec = 1'b1;
                if (i_sts.mcnt_one) begin
                    n_state = smle_pkg::ST_IDLE;
                end else begin
                    o_cmd.rd = smle_pkg::RD_SAVED;
                    n_state  = smle_pkg::ST_WALK2;
                end
            end
            smle_pkg::ST_E_OK, smle_pkg::ST_E_NF, smle_pkg::ST_E_FULL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    o_cmd.code = (r_state == smle_pkg::ST_E_OK) ? smle_pkg::CODE_OK :
                                 (r_state == smle_pkg::ST_E_NF) ? smle_pkg::CODE_NF :
                                                                 smle_pkg::CODE_FULL;
                    n_state = smle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = smle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/smle_dp.sv =====
// Datapath for the list engine: node memories, list pointers, output register.
module smle_dp #(
    parameter int CAPACITY = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_data,
    input  logic            i_in_valid,
    input  logic [71:0]     i_in_data,
    input  logic            i_out_ready,
    input  smle_pkg::t_cmd  i_cmd,
    output smle_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    output logic [39:0]     o_out_data,
    output logic            o_out_last
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int AW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] NIL = AW'(CAPACITY);

    logic [31:0]   mem_key   [CAPACITY];
    logic [31:0]   mem_value [CAPACITY];
    logic [AW-1:0] mem_next  [CAPACITY];
    logic [AW-1:0] mem_prev  [CAPACITY];
    logic [CAPACITY-1:0] r_nvld, r_pvld;

    logic [31:0]   q_key, q_value;
    logic [AW-1:0] q_next, q_prev;

    logic          r_order;
    logic [1:0]    r_func;
    logic [31:0]   r_key, r_value, r_val;
    logic [AW-1:0] r_head, r_tail, r_free, r_count, r_rep;
    logic [AW-1:0] r_cur, r_n, r_p, r_q, r_first;
    logic [smle_pkg::MCNT_W-1:0] r_mcnt;
    logic          r_ovalid;
    logic [39:0]   r_odata;
    logic          r_olast;

    logic [AW-1:0] rd_addr, plink;
    logic          rd_en;
    logic          nx_we, pv_we, kv_we;
    logic [AW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;
    logic          out_free;

    function automatic logic is_node(input logic [AW-1:0] x);
        return x < NIL;
    endfunction

    function automatic logic [IW-1:0] idx(input logic [AW-1:0] x);
        return is_node(x) ? IW'(x) : '0;
    endfunction

    always_comb begin
        case (i_cmd.rd)
            smle_pkg::RD_HEAD:  rd_addr = r_head;
            smle_pkg::RD_NEXT:  rd_addr = q_next;
            smle_pkg::RD_SAVED: rd_addr = r_q;
            smle_pkg::RD_FIRST: rd_addr = r_first;
            smle_pkg::RD_FREE:  rd_addr = r_free;
            default:            rd_addr = r_cur;
        endcase
        rd_en = (i_cmd.rd != smle_pkg::RD_NONE);
    end

    assign plink = is_node(r_cur) ? r_p : r_tail;

    // one write per link memory per cycle
    always_comb begin
        nx_we = 1'b0; nx_wa = r_cur; nx_wd = r_cur;
        pv_we = 1'b0; pv_wa = r_cur; pv_wd = r_cur;
        kv_we = 1'b0;
        case (i_cmd.wr)
            smle_pkg::WR_POP: begin
                pv_we = is_node(q_next); pv_wa = q_next; pv_wd = NIL;
            end
            smle_pkg::WR_LINK_N: begin
                kv_we = 1'b1;
                nx_we = 1'b1; nx_wa = r_n; nx_wd = r_cur;
                pv_we = 1'b1; pv_wa = r_n; pv_wd = plink;
            end
            smle_pkg::WR_LINK_NB: begin
                nx_we = is_node(r_p);   nx_wa = r_p;   nx_wd = r_n;
                pv_we = is_node(r_cur); pv_wa = r_cur; pv_wd = r_n;
            end
            smle_pkg::WR_UL_NB: begin
                nx_we = is_node(r_p); nx_wa = r_p; nx_wd = r_q;
                pv_we = is_node(r_q); pv_wa = r_q; pv_wd = r_p;
            end
            smle_pkg::WR_UL_FREE: begin
                nx_we = 1'b1; nx_wa = r_cur; nx_wd = r_free;
                pv_we = 1'b1; pv_wa = r_cur; pv_wd = NIL;
            end
            smle_pkg::WR_UL_FH: begin
                pv_we = is_node(r_free); pv_wa = r_free; pv_wd = r_cur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            mem_key[idx(r_n)]   <= r_key;
            mem_value[idx(r_n)] <= r_value;
        end
        if (nx_we) mem_next[idx(nx_wa)] <= nx_wd;
        if (pv_we) mem_prev[idx(pv_wa)] <= pv_wd;
        if (rd_en) begin
            q_key   <= mem_key[idx(rd_addr)];
            q_value <= mem_value[idx(rd_addr)];
            // unwritten links read as the reset free chain
            q_next  <= r_nvld[idx(rd_addr)] ? mem_next[idx(rd_addr)] :
                       AW'(idx(rd_addr)) + AW'(1);
            q_prev  <= r_pvld[idx(rd_addr)] ? mem_prev[idx(rd_addr)] :
                       (idx(rd_addr) == '0) ? NIL : AW'(idx(rd_addr)) - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld <= '0;
            r_pvld <= '0;
        end else begin
            if (nx_we) r_nvld[idx(nx_wa)] <= 1'b1;
            if (pv_we) r_pvld[idx(pv_wa)] <= 1'b1;
        end
    end

    assign out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order  <= 1'b0;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_free   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_order <= i_cfg_data;
            case (i_cmd.wr)
                smle_pkg::WR_POP: r_free <= q_next;
                smle_pkg::WR_LINK_NB: begin
                    if (!is_node(r_p))   r_head <= r_n;
                    if (!is_node(r_cur)) r_tail <= r_n;
                    r_count <= r_count + AW'(1);
                end
                smle_pkg::WR_UL_NB: begin
                    if (!is_node(r_p)) r_head <= r_q;
                    if (!is_node(r_q)) r_tail <= r_p;
                end
                smle_pkg::WR_UL_FH: begin
                    r_free <= r_cur;
                    if (r_count != '0) r_count <= r_count - AW'(1);
                end
                default: begin
                end
            endcase
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_rdy && i_in_valid) begin
            r_func  <= i_in_data[1:0];
            r_key   <= i_in_data[33:2];
            r_value <= i_in_data[65:34];
        end
        if (rd_en && i_cmd.rd != smle_pkg::RD_FREE) r_cur <= rd_addr;
        if (i_cmd.wr == smle_pkg::WR_POP) r_n <= r_free;
        if (i_cmd.wr == smle_pkg::WR_LINK_N) r_p <= plink;
        if (i_cmd.cap) begin
            r_p   <= q_prev;
            r_q   <= q_next;
            r_val <= q_value;
        end
        if (i_cmd.first_ld) r_first <= r_cur;
        if (i_cmd.mcnt_clr) begin
            r_mcnt <= '0;
        end else if (i_cmd.mcnt_inc) begin
            r_mcnt <= r_mcnt + 1'b1;
        end else if (i_cmd.mcnt_dec) begin
            r_mcnt <= r_mcnt - 1'b1;
        end
        // remove-key reports the count left after all its deletions
        if (i_cmd.rep_ld) begin
            r_rep <= (r_func == smle_pkg::FN_REMOVE_KEY) ? r_count - AW'(r_mcnt) : r_count;
        end
        if (i_cmd.emit) begin
            r_odata <= {6'(i_cmd.cnt_rep ? r_rep : r_count), i_cmd.code,
                        i_cmd.val_sel ? r_val : 32'd0};
            r_olast <= i_cmd.last;
        end
    end

    always_comb begin
        o_sts.func       = smle_pkg::t_func'(r_func);
        o_sts.cur_node   = is_node(r_cur);
        o_sts.key_eq     = (q_key == r_key);
        o_sts.val_eq     = (q_value == r_value);
        o_sts.goes_first = r_order ? ($signed(r_key) >= $signed(q_key)) :
                                     ($signed(r_key) <= $signed(q_key));
        o_sts.free_node  = is_node(r_free);
        o_sts.mcnt_full  = (r_mcnt == smle_pkg::MCNT_W'(smle_pkg::MAX_RESULTS));
        o_sts.mcnt_one   = (r_mcnt == smle_pkg::MCNT_W'(1));
        o_sts.out_free   = out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_last  = r_olast;

endmodule

// ===== hw/rtl/sorted_multimap_list_engine_unit.sv =====
// Sorted multimap list engine: top level.
// Keeps up to CAPACITY key/value pairs as a sorted doubly linked list with a
// free list of unused nodes. Input transfers on the s_axis channel carry one
// operation (insert, search, remove pair, remove all of key); results leave
// on the m_axis channel, one or more per operation, tlast on the final one.
// Every result carries the entry count after the whole operation.
// The cfg channel writes the order bit (0 ascending, 1 descending); it is
// always ready. The user must write it only while idle; the block does not check.
// One operation at a time: tready is high only when the sequencer is idle.
// The list walk reads one node per cycle through the node memories. Insert
// walks to its place and links the new node, remove pair walks to the match
// (or to the tail on a miss); search walks p nodes to the run of m equal
// keys, counts it, then walks it again issuing one result per pair, held
// while the receiver stalls; remove-key adds the unlink states UL1, UL2 and
// UL3 for each pair.
// Results pass through an output register; a stalled receiver holds the
// sequencer at its next result but the last result never blocks the next
// input transfer. Reset empties the list at once (link memories carry
// per-entry valid bits), no clearing pass.
module sorted_multimap_list_engine_unit #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // order_mode
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // func[1:0], key[33:2], value[65:34], zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // value_out[31:0], status[33:32], entry_count[39:34]
    output logic        o_m_axis_tlast
);

    smle_pkg::t_cmd cmd;
    smle_pkg::t_sts sts;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = cmd.in_rdy;

    smle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while an operation is in flight");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result issued over a pending result");

    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr == smle_pkg::WR_POP) |-> sts.free_node)
        else $error("node taken from an empty free list");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[33:32] == smle_pkg::CODE_FULL)
        |-> (o_m_axis_tdata[39:34] == 6'(CAPACITY)))
        else $error("full reported below capacity");
`endif

endmodule

// ===== bench/sorted_multimap_list_engine_unit_tb.sv =====
// Self-checking bench for the sorted multimap list engine: random ops vs. a sorted-pair predictor.
`timescale 1ns / 100ps

module sorted_multimap_list_engine_unit_tb;

    localparam int CAP = 32;
    localparam int SETTLE = 300;

    typedef struct {
        smle_pkg::t_func f;
        logic [31:0]     k;
        logic [31:0]     v;
    } t_op;

    typedef struct {
        logic [31:0] k;
        logic [31:0] v;
    } t_pair;

    typedef struct {
        logic [31:0]     val;
        smle_pkg::t_code code;
        logic [5:0]      cnt;
        logic            last;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata;  // func[1:0], key[33:2], value[65:34], zero pad
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;  // value_out[31:0], status[33:32], entry_count[39:34]
    logic        o_m_axis_tlast;

    sorted_multimap_list_engine_unit #(.CAPACITY(CAP)) uut (.*);

    t_op   op_queue[$];
    t_pair list_pairs[$];
    t_res  expected_results[$];
    logic  order_desc;
    int    mismatches;
    int    idle_pct;
    int    stall_pct;
    logic  hold_off;
    logic  pressure_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic goes_before(logic [31:0] nk, logic [31:0] sk);
        if (order_desc)
            return $signed(nk) >= $signed(sk);
        return $signed(nk) <= $signed(sk);
    endfunction

    task automatic push_result(logic [31:0] val, smle_pkg::t_code code, logic last);
        t_res r;
        r.val  = val;
        r.code = code;
        r.cnt  = 6'(list_pairs.size());
        r.last = last;
        expected_results = {expected_results, r};
    endtask

    // Applies one operation to the pair list and queues the results it yields
    task automatic apply_op(t_op op);
        int          idx;
        t_pair       p;
        logic [31:0] hits[$];
        idx = -1;
        case (op.f)
            smle_pkg::FN_INSERT: begin
                if (list_pairs.size() >= CAP) begin
                    push_result('0, smle_pkg::CODE_FULL, 1'b1);
                end else begin
                    idx = list_pairs.size();
                    for (int i = 0; i < list_pairs.size(); i++)
                        if (goes_before(op.k, list_pairs[i].k)) begin
                            idx = i;
                            break;
                        end
                    p.k = op.k;
                    p.v = op.v;
                    list_pairs.insert(idx, p);
                    push_result('0, smle_pkg::CODE_OK, 1'b1);
                end
            end
            smle_pkg::FN_REMOVE: begin
                for (int i = 0; i < list_pairs.size(); i++)
                    if (list_pairs[i].k == op.k && list_pairs[i].v == op.v) begin
                        idx = i;
                        break;
                    end
                if (idx >= 0) list_pairs.delete(idx);
                push_result('0, (idx >= 0) ? smle_pkg::CODE_OK : smle_pkg::CODE_NF, 1'b1);
            end
            default: begin
                for (int i = 0; i < list_pairs.size(); i++)
                    if (list_pairs[i].k == op.k) begin
                        idx = i;
                        break;
                    end
                // only the contiguous run from the first match is reported
                if (idx >= 0) begin
                    while (idx < list_pairs.size() && list_pairs[idx].k == op.k) begin
                        hits = {hits, list_pairs[idx].v};
                        if (op.f == smle_pkg::FN_REMOVE_KEY) list_pairs.delete(idx);
                        else idx++;
                    end
                end
                if (hits.size() == 0)
                    push_result('0, smle_pkg::CODE_NF, 1'b1);
                foreach (hits[i])
                    push_result(hits[i], smle_pkg::CODE_OK, i == hits.size() - 1);
            end
        endcase
    endtask

    // Input driver
    always @(negedge i_clk) begin
        if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (op_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                t_op op;
                op = op_queue.pop_front();
                i_s_axis_tdata  <= {6'b0, op.v, op.k, op.f};
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
        i_m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Predictor and result checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) order_desc = i_cfg_data;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: data %h last %b",
                                 o_m_axis_tdata, o_m_axis_tlast);
                end else begin
                    t_res r;
                    r = expected_results.pop_front();
                    if (o_m_axis_tdata[31:0] !== r.val || o_m_axis_tdata[33:32] !== r.code
                        || o_m_axis_tdata[39:34] !== r.cnt || o_m_axis_tlast !== r.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                                     r.val, r.code, r.cnt, r.last, o_m_axis_tdata[31:0],
                                     o_m_axis_tdata[33:32], o_m_axis_tdata[39:34],
                                     o_m_axis_tlast);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                t_op op;
                op.f = smle_pkg::t_func'(i_s_axis_tdata[1:0]);
                op.k = i_s_axis_tdata[33:2];
                op.v = i_s_axis_tdata[65:34];
                apply_op(op);
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial begin
        hold_off = 1'b0;
        wait (pressure_req);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (600) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom();
            default: return 32'($signed($urandom_range(6)) - 3);
        endcase
    endfunction

    function automatic logic [31:0] pick_val();
        return ($urandom_range(4) == 0) ? $urandom() : 32'($urandom_range(3));
    endfunction

    task automatic add_op(smle_pkg::t_func f, logic [31:0] k, logic [31:0] v);
        t_op op;
        op.f = f;
        op.k = k;
        op.v = v;
        op_queue = {op_queue, op};
    endtask

    task automatic add_random(int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(9);
            if (sel < 4)      add_op(smle_pkg::FN_INSERT, pick_key(), pick_val());
            else if (sel < 6) add_op(smle_pkg::FN_SEARCH, pick_key(), $urandom());
            else if (sel < 8) add_op(smle_pkg::FN_REMOVE, pick_key(), pick_val());
            else              add_op(smle_pkg::FN_REMOVE_KEY, pick_key(), $urandom());
        end
    endtask

    // everything sent, accepted and checked before the next phase
    task automatic drain();
        do @(posedge i_clk);
        while (op_queue.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_order(logic mode);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        order_desc      = 1'b0;
        mismatches      = 0;
        idle_pct        = 0;
        stall_pct       = 0;
        pressure_req    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_order(1'b0);
        // empty-list misses, extremes, duplicate keys, multi-hit search and removes
        add_op(smle_pkg::FN_SEARCH, 32'd5, '0);
        add_op(smle_pkg::FN_REMOVE, 32'd5, 32'd1);
        add_op(smle_pkg::FN_REMOVE_KEY, 32'd5, '0);
        add_op(smle_pkg::FN_INSERT, 32'h8000_0000, 32'hffff_ffff);
        add_op(smle_pkg::FN_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        add_op(smle_pkg::FN_INSERT, 32'd0, 32'h7fff_ffff);
        add_op(smle_pkg::FN_INSERT, 32'd7, 32'd1);
        add_op(smle_pkg::FN_INSERT, 32'd7, 32'd2);
        add_op(smle_pkg::FN_INSERT, 32'd7, 32'd3);
        add_op(smle_pkg::FN_INSERT, 32'hffff_ffff, 32'h5555_aaaa);
        add_op(smle_pkg::FN_SEARCH, 32'd7, '0);
        add_op(smle_pkg::FN_SEARCH, 32'h8000_0000, '0);
        add_op(smle_pkg::FN_SEARCH, 32'd8, '0);
        add_op(smle_pkg::FN_REMOVE, 32'd7, 32'd2);
        add_op(smle_pkg::FN_REMOVE, 32'd7, 32'd9);
        add_op(smle_pkg::FN_SEARCH, 32'd7, '0);
        add_op(smle_pkg::FN_REMOVE_KEY, 32'd7, '0);
        add_op(smle_pkg::FN_REMOVE_KEY, 32'd7, '0);
        add_op(smle_pkg::FN_SEARCH, 32'h7fff_ffff, 32'hffff_ffff);
        add_op(smle_pkg::FN_REMOVE_KEY, 32'hffff_ffff, '0);
        drain();

        // descending order; fill past capacity, then a large remove-key
        write_order(1'b1);
        idle_pct = 78;
        for (int i = 0; i < CAP + 2; i++)
            add_op(smle_pkg::FN_INSERT, ($urandom_range(1) != 0) ? 32'd3 : pick_key(),
                   $urandom());
        add_op(smle_pkg::FN_SEARCH, 32'd3, '0);
        add_op(smle_pkg::FN_REMOVE_KEY, 32'd3, '0);
        add_random(10);
        drain();

        write_order(1'b0);
        idle_pct  = 0;
        stall_pct = 78;
        add_random(25);
        pressure_req = 1'b1;
        drain();

        write_order(1'b1);
        idle_pct  = 36;
        stall_pct = 36;
        add_random(25);
        drain();

        write_order(1'b0);
        idle_pct  = 0;
        stall_pct = 0;
        add_random(15);
        drain();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
